// ===== sv/pinyin_syllable_to_viseme_timing_unit_defines.svh =====
// Assertion macros shared by the viseme timing RTL.
// Included by the modules that check their own control logic.
`ifndef PINYIN_SYLLABLE_TO_VISEME_TIMING_UNIT_DEFINES_SVH
`define PINYIN_SYLLABLE_TO_VISEME_TIMING_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define PSTV_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled in reset
`define PSTV_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PSTV_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define PSTV_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/pstv_pkg.sv =====
// Shared constants, types and the letter classifier of the viseme timing unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package pstv_pkg;

   localparam int MAX_LETTERS_DEF = 6;
   localparam int MAX_VISEMES_DEF = 5;
   localparam int LETTER_PORTS    = 6;
   localparam int LOOKAHEAD       = 3;
   localparam int QUEUE_DEPTH     = 2;

   localparam int LTR_W   = 5;
   localparam int VIS_W   = 5;
   localparam int MS_W    = 16;
   localparam int FRAC_W  = 8;
   localparam int STEP_W  = MS_W + FRAC_W;
   localparam int TIME_W  = 32;
   localparam int ADV_W   = 3;

   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int DIV_CYCLES         = STEP_W / DIV_BITS_PER_CYCLE;

   // letter codes
   localparam logic [LTR_W-1:0] LTR_NONE = 5'd0;
   localparam logic [LTR_W-1:0] LTR_A = 5'd1;
   localparam logic [LTR_W-1:0] LTR_B = 5'd2;
   localparam logic [LTR_W-1:0] LTR_C = 5'd3;
   localparam logic [LTR_W-1:0] LTR_D = 5'd4;
   localparam logic [LTR_W-1:0] LTR_E = 5'd5;
   localparam logic [LTR_W-1:0] LTR_F = 5'd6;
   localparam logic [LTR_W-1:0] LTR_G = 5'd7;
   localparam logic [LTR_W-1:0] LTR_H = 5'd8;
   localparam logic [LTR_W-1:0] LTR_I = 5'd9;
   localparam logic [LTR_W-1:0] LTR_J = 5'd10;
   localparam logic [LTR_W-1:0] LTR_K = 5'd11;
   localparam logic [LTR_W-1:0] LTR_L = 5'd12;
   localparam logic [LTR_W-1:0] LTR_M = 5'd13;
   localparam logic [LTR_W-1:0] LTR_N = 5'd14;
   localparam logic [LTR_W-1:0] LTR_O = 5'd15;
   localparam logic [LTR_W-1:0] LTR_P = 5'd16;
   localparam logic [LTR_W-1:0] LTR_Q = 5'd17;
   localparam logic [LTR_W-1:0] LTR_R = 5'd18;
   localparam logic [LTR_W-1:0] LTR_S = 5'd19;
   localparam logic [LTR_W-1:0] LTR_T = 5'd20;
   localparam logic [LTR_W-1:0] LTR_U = 5'd21;
   localparam logic [LTR_W-1:0] LTR_V = 5'd22;
   localparam logic [LTR_W-1:0] LTR_W_ = 5'd23;
   localparam logic [LTR_W-1:0] LTR_X = 5'd24;
   localparam logic [LTR_W-1:0] LTR_Y = 5'd25;
   localparam logic [LTR_W-1:0] LTR_Z = 5'd26;
   localparam logic [LTR_W-1:0] LTR_LAST = LTR_Z;

   // viseme codes
   localparam logic [VIS_W-1:0] VIS_SILENCE = 5'd0;
   localparam logic [VIS_W-1:0] VIS_DTN     = 5'd1;
   localparam logic [VIS_W-1:0] VIS_L       = 5'd3;
   localparam logic [VIS_W-1:0] VIS_GKH     = 5'd5;
   localparam logic [VIS_W-1:0] VIS_JQX     = 5'd7;
   localparam logic [VIS_W-1:0] VIS_RETRO   = 5'd9;
   localparam logic [VIS_W-1:0] VIS_ZCS     = 5'd11;
   localparam logic [VIS_W-1:0] VIS_ROUND_LIMIT = 5'd12;
   localparam logic [VIS_W-1:0] VIS_BPM     = 5'd13;
   localparam logic [VIS_W-1:0] VIS_F       = 5'd14;
   localparam logic [VIS_W-1:0] VIS_A       = 5'd15;
   localparam logic [VIS_W-1:0] VIS_AI      = 5'd16;
   localparam logic [VIS_W-1:0] VIS_AO      = 5'd17;
   localparam logic [VIS_W-1:0] VIS_O       = 5'd18;
   localparam logic [VIS_W-1:0] VIS_OU      = 5'd19;
   localparam logic [VIS_W-1:0] VIS_E       = 5'd20;
   localparam logic [VIS_W-1:0] VIS_EI      = 5'd21;
   localparam logic [VIS_W-1:0] VIS_ER      = 5'd22;
   localparam logic [VIS_W-1:0] VIS_I       = 5'd23;
   localparam logic [VIS_W-1:0] VIS_U       = 5'd24;
   localparam logic [VIS_W-1:0] VIS_YU      = 5'd25;

   // what one scan step does
   typedef struct packed {
      logic             rnd;   // raise previous viseme
      logic [1:0]       nput;  // visemes produced, 0..2
      logic [VIS_W-1:0] v1;
      logic [VIS_W-1:0] v2;
      logic [ADV_W-1:0] adv;   // letters consumed, 1..4
   } letter_act_type;

   // one finished syllable, minus its viseme list
   typedef struct packed {
      logic [MS_W-1:0]   pause_ms;
      logic [STEP_W-1:0] step;
      logic              final_syl;
   } job_head_type;

   function automatic letter_act_type classify(
      input logic [LTR_W-1:0] cur,
      input logic [LTR_W-1:0] n1,
      input logic [LTR_W-1:0] n2,
      input logic [LTR_W-1:0] n3,
      input logic [LTR_W-1:0] prev,
      input logic             have_last,
      input logic [VIS_W-1:0] last
   );
      letter_act_type act;
      act.rnd  = 1'b0;
      act.nput = 2'd0;
      act.v1   = VIS_SILENCE;
      act.v2   = VIS_SILENCE;
      act.adv  = 3'd1;
      unique case (cur)
         LTR_B, LTR_P, LTR_M: begin
            act.nput = 2'd1; act.v1 = VIS_BPM;
         end
         LTR_F: begin
            act.v1 = VIS_F; act.v2 = VIS_F;
            if (n1 == LTR_U) begin
               act.nput = 2'd2; act.adv = 3'd2;
            end else begin
               act.nput = 2'd1;
            end
         end
         LTR_D, LTR_T, LTR_N: begin
            act.nput = 2'd1; act.v1 = VIS_DTN;
         end
         LTR_L: begin
            act.nput = 2'd1; act.v1 = VIS_L;
         end
         LTR_G, LTR_K, LTR_H: begin
            act.nput = 2'd1; act.v1 = VIS_GKH;
         end
         LTR_J, LTR_Q, LTR_X: begin
            act.nput = 2'd1; act.v1 = VIS_JQX;
         end
         LTR_Z, LTR_C, LTR_S: begin
            act.nput = 2'd1;
            if (n1 == LTR_H) begin
               act.v1 = VIS_RETRO; act.adv = 3'd2;
            end else begin
               act.v1 = VIS_ZCS;
            end
         end
         LTR_R: begin
            act.nput = 2'd1; act.v1 = VIS_RETRO;
         end
         LTR_A: begin
            act.nput = 2'd1;
            if (n1 == LTR_O) begin
               act.v1 = VIS_AO; act.adv = 3'd2;
            end else if (n1 == LTR_I) begin
               act.v1 = VIS_AI; act.adv = 3'd2;
            end else if (n1 == LTR_N) begin
               if (n2 == LTR_G) begin
                  act.v1 = VIS_A; act.adv = 3'd3;
               end else begin
                  act.v1 = VIS_AI; act.adv = 3'd2;
               end
            end else begin
               act.v1 = VIS_A;
            end
         end
         LTR_O: begin
            act.nput = 2'd1;
            if (n1 == LTR_U) begin
               act.v1 = VIS_OU; act.adv = 3'd2;
            end else if (n1 == LTR_N && n2 == LTR_G) begin
               act.rnd = 1'b1; act.v1 = VIS_U; act.adv = 3'd3;
            end else begin
               act.v1 = VIS_O;
            end
         end
         LTR_E: begin
            act.nput = 2'd1;
            if (n1 == LTR_I || n1 == LTR_N) begin
               act.v1 = VIS_EI;
               act.adv = (n1 == LTR_N && n2 == LTR_G) ? 3'd3 : 3'd2;
            end else if (n1 == LTR_R) begin
               act.v1 = VIS_ER; act.adv = 3'd2;
            end else begin
               act.v1 = VIS_E;
            end
         end
         LTR_I: begin
            if (have_last && (last == VIS_JQX || last == VIS_RETRO || last == VIS_ZCS)) begin
               act.nput = 2'd1; act.v1 = last;
            end else if (n1 == LTR_O && n2 == LTR_N && n3 == LTR_G) begin
               act.rnd = 1'b1; act.nput = 2'd2;
               act.v1 = VIS_YU; act.v2 = VIS_EI; act.adv = 3'd4;
            end else if (n1 == LTR_N) begin
               act.nput = 2'd2; act.v1 = VIS_I; act.v2 = VIS_EI;
               act.adv = (n2 == LTR_G) ? 3'd3 : 3'd2;
            end else begin
               act.nput = 2'd1; act.v1 = VIS_I;
            end
         end
         LTR_U: begin
            act.rnd = 1'b1;
            if (n1 == LTR_E) begin
               act.nput = 2'd2; act.v1 = VIS_YU; act.v2 = VIS_E; act.adv = 3'd2;
            end else if (n1 == LTR_N) begin
               act.nput = 2'd2; act.v1 = VIS_U; act.v2 = VIS_EI; act.adv = 3'd2;
            end else begin
               act.nput = 2'd1;
               act.v1 = (prev == LTR_Y) ? VIS_YU : VIS_U;
            end
         end
         LTR_V: begin
            act.rnd = 1'b1;
            act.v1  = VIS_YU;
            if (n1 == LTR_E) begin
               act.nput = 2'd2; act.v2 = VIS_E; act.adv = 3'd2;
            end else if (n1 == LTR_N) begin
               act.nput = 2'd2; act.v2 = VIS_EI; act.adv = 3'd2;
            end else begin
               act.nput = 2'd1;
            end
         end
         LTR_Y: begin
            if (n1 == LTR_A || n1 == LTR_E) begin
               act.nput = 2'd1; act.v1 = VIS_I;
            end else if (n1 == LTR_O) begin
               if (n2 == LTR_U) begin
                  act.nput = 2'd2; act.v1 = VIS_I; act.v2 = VIS_OU; act.adv = 3'd3;
               end else if (n2 == LTR_N && n3 == LTR_G) begin
                  act.nput = 2'd1; act.v1 = VIS_YU; act.adv = 3'd4;
               end
            end
         end
         LTR_W_: begin
            if (n1 == LTR_A || n1 == LTR_E) begin
               act.nput = 2'd1; act.v1 = VIS_U;
            end
         end
         default: begin
            act.nput = 2'd0;
         end
      endcase
      return act;
   endfunction

endpackage

`default_nettype wire

// ===== sv/pstv_front.sv =====
// Front end: accepts a syllable, scans its letters into visemes one step a
// cycle, then divides the duration by the viseme count. Uses pstv_pkg.
`default_nettype none
`include "pinyin_syllable_to_viseme_timing_unit_defines.svh"

module pstv_front import pstv_pkg::*; #(
   parameter int MAX_LETTERS = MAX_LETTERS_DEF,
   parameter int MAX_VISEMES = MAX_VISEMES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [LTR_W-1:0]                     req_letter_a,
   input  logic [LTR_W-1:0]                     req_letter_b,
   input  logic [LTR_W-1:0]                     req_letter_c,
   input  logic [LTR_W-1:0]                     req_letter_d,
   input  logic [LTR_W-1:0]                     req_letter_e,
   input  logic [LTR_W-1:0]                     req_letter_f,
   input  logic [MS_W-1:0]                      req_pause_ms,
   input  logic [MS_W-1:0]                      req_duration_ms,
   input  logic                                 req_final_syllable,
   input  logic                                 q_full,
   output logic                                 q_push,
   output job_head_type                         job_head,
   output logic [$clog2(MAX_VISEMES+1)-1:0]     job_cnt,
   output logic [VIS_W-1:0]                     job_vis [MAX_VISEMES]
);

   localparam int VCW  = $clog2(MAX_VISEMES + 1);
   localparam int LBUF = MAX_LETTERS + LOOKAHEAD + 1;
   localparam int PW   = $clog2(LBUF);
   localparam int DCW  = $clog2(DIV_CYCLES);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_SCAN = 4'b0010,
      F_DIV  = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic [LTR_W-1:0]  win_ff  [LBUF];
   logic [LTR_W-1:0]  win_in  [LBUF];
   logic [LTR_W-1:0]  prev_ff, prev_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [VIS_W-1:0]  vis_ff  [MAX_VISEMES];
   logic [VIS_W-1:0]  vis_in  [MAX_VISEMES];
   logic [VCW-1:0]    cnt_ff, cnt_in;
   logic [VIS_W-1:0]  last_ff, last_in;
   logic [MS_W-1:0]   pause_ff, pause_in;
   logic [MS_W-1:0]   dur_ff, dur_in;
   logic              final_ff, final_in;
   logic [STEP_W-1:0] quo_ff, quo_in;
   logic [VCW-1:0]    rem_ff, rem_in;
   logic [DCW-1:0]    dcnt_ff, dcnt_in;

   letter_act_type    act;
   logic              accept;
   logic              scan_done;
   logic [LTR_W-1:0]  letters [LETTER_PORTS];

   assign letters[0] = req_letter_a;
   assign letters[1] = req_letter_b;
   assign letters[2] = req_letter_c;
   assign letters[3] = req_letter_d;
   assign letters[4] = req_letter_e;
   assign letters[5] = req_letter_f;

   assign full      = (state_ff != F_IDLE);
   assign accept    = push && !full;
   assign scan_done = (pos_ff >= PW'(MAX_LETTERS)) || (win_ff[0] == LTR_NONE);
   assign q_push    = (state_ff == F_PUSH) && !q_full;

   assign job_head.pause_ms  = pause_ff;
   assign job_head.step      = quo_ff;
   assign job_head.final_syl = final_ff;
   assign job_cnt            = cnt_ff;
   assign job_vis            = vis_ff;

   always_comb begin
      act = classify(win_ff[0], win_ff[1], win_ff[2], win_ff[3], prev_ff,
                     cnt_ff != '0, last_ff);
   end

   // main sequencer
   always_comb begin
      logic             stop;
      logic [LTR_W-1:0] c;
      logic [VIS_W-1:0] b [MAX_VISEMES];
      logic [VCW-1:0]   n;
      logic [VIS_W-1:0] l;
      logic [LTR_W-1:0] w [LBUF];
      logic [LTR_W-1:0] p;
      logic [VCW:0]     t;
      logic [VCW-1:0]   r;
      logic [STEP_W-1:0] q;

      state_in = state_ff;
      win_in   = win_ff;
      prev_in  = prev_ff;
      pos_in   = pos_ff;
      vis_in   = vis_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      pause_in = pause_ff;
      dur_in   = dur_ff;
      final_in = final_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;

      stop = 1'b0;
      c    = LTR_NONE;
      b    = vis_ff;
      n    = cnt_ff;
      l    = last_ff;
      w    = win_ff;
      p    = prev_ff;
      t    = '0;
      r    = rem_ff;
      q    = quo_ff;

      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               // letters after the first gap or bad code read as none
               for (int k = 0; k < LBUF; k++) begin
                  c = LTR_NONE;
                  if (k < MAX_LETTERS && k < LETTER_PORTS) begin
                     c = letters[k];
                  end
                  if (c == LTR_NONE || c > LTR_LAST) begin
                     stop = 1'b1;
                  end
                  win_in[k] = stop ? LTR_NONE : c;
               end
               prev_in  = LTR_NONE;
               pos_in   = '0;
               cnt_in   = '0;
               last_in  = VIS_SILENCE;
               pause_in = req_pause_ms;
               dur_in   = req_duration_ms;
               final_in = req_final_syllable;
               state_in = F_SCAN;
            end
         end
         F_SCAN: begin
            if (scan_done) begin
               if (cnt_ff == '0) begin
                  vis_in[0] = VIS_SILENCE;
                  cnt_in    = VCW'(1);
               end
               quo_in   = {dur_ff, {FRAC_W{1'b0}}};
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = F_DIV;
            end else begin
               if (act.rnd && n != '0 && l < VIS_ROUND_LIMIT) begin
                  l = l + VIS_W'(1);
                  for (int k = 0; k < MAX_VISEMES; k++) begin
                     if (VCW'(k) == n - VCW'(1)) b[k] = l;
                  end
               end
               if (act.nput != 2'd0 && n < VCW'(MAX_VISEMES)) begin
                  for (int k = 0; k < MAX_VISEMES; k++) begin
                     if (VCW'(k) == n) b[k] = act.v1;
                  end
                  n = n + VCW'(1);
                  l = act.v1;
               end
               if (act.nput == 2'd2 && n < VCW'(MAX_VISEMES)) begin
                  for (int k = 0; k < MAX_VISEMES; k++) begin
                     if (VCW'(k) == n) b[k] = act.v2;
                  end
                  n = n + VCW'(1);
                  l = act.v2;
               end
               // slide the letter window, remembering the letter left behind
               for (int s = 1; s <= 4; s++) begin
                  if (ADV_W'(s) <= act.adv) begin
                     p = w[0];
                     for (int k = 0; k < LBUF - 1; k++) begin
                        w[k] = w[k + 1];
                     end
                     w[LBUF - 1] = LTR_NONE;
                  end
               end
               vis_in  = b;
               cnt_in  = n;
               last_in = l;
               win_in  = w;
               prev_in = p;
               pos_in  = pos_ff + PW'(act.adv);
            end
         end
         F_DIV: begin
            // restoring division, a few quotient bits per cycle
            for (int j = 0; j < DIV_BITS_PER_CYCLE; j++) begin
               t = {r, q[STEP_W-1]};
               q = {q[STEP_W-2:0], 1'b0};
               if (t >= {1'b0, cnt_ff}) begin
                  t    = t - {1'b0, cnt_ff};
                  q[0] = 1'b1;
               end
               r = t[VCW-1:0];
            end
            quo_in  = q;
            rem_in  = r;
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(DIV_CYCLES - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      prev_ff  <= prev_in;
      pos_ff   <= pos_in;
      vis_ff   <= vis_in;
      cnt_ff   <= cnt_in;
      last_ff  <= last_in;
      pause_ff <= pause_in;
      dur_ff   <= dur_in;
      final_ff <= final_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
   end

   `PSTV_ASSERT_IMP(a_push_has_visemes, clock, reset, q_push, job_cnt != '0, "empty viseme list queued")
   `PSTV_ASSERT_IMP(a_count_bounded, clock, reset, state_ff != F_IDLE, cnt_ff <= VCW'(MAX_VISEMES), "viseme count over limit")
   `PSTV_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, full && state_ff == F_SCAN, "accept did not start a scan")

endmodule

`default_nettype wire

// ===== sv/pstv_queue.sv =====
// Short queue of finished syllable jobs between front and back end.
// Uses pstv_pkg for the job header type and the queue depth.
`default_nettype none

module pstv_queue import pstv_pkg::*; #(
   parameter int MAX_VISEMES = MAX_VISEMES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_push,
   output logic                             wr_full,
   input  job_head_type                     wr_head,
   input  logic [$clog2(MAX_VISEMES+1)-1:0] wr_cnt,
   input  logic [VIS_W-1:0]                 wr_vis [MAX_VISEMES],
   input  logic                             rd_pop,
   output logic                             rd_empty,
   output job_head_type                     rd_head,
   output logic [$clog2(MAX_VISEMES+1)-1:0] rd_cnt,
   output logic [VIS_W-1:0]                 rd_vis [MAX_VISEMES]
);

   localparam int VCW = $clog2(MAX_VISEMES + 1);
   localparam int PTW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   job_head_type     head_mem [QUEUE_DEPTH];
   logic [VCW-1:0]   cnt_mem  [QUEUE_DEPTH];
   logic [VIS_W-1:0] vis_mem  [QUEUE_DEPTH][MAX_VISEMES];

   logic [PTW-1:0] wptr_ff, wptr_in;
   logic [PTW-1:0] rptr_ff, rptr_in;
   logic [QCW-1:0] fill_ff, fill_in;
   logic           do_wr, do_rd;

   assign wr_full  = (fill_ff == QCW'(QUEUE_DEPTH));
   assign rd_empty = (fill_ff == '0);
   assign do_wr    = wr_push && !wr_full;
   assign do_rd    = rd_pop && !rd_empty;

   assign rd_head = head_mem[rptr_ff];
   assign rd_cnt  = cnt_mem[rptr_ff];
   assign rd_vis  = vis_mem[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == PTW'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + PTW'(1);
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == PTW'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + PTW'(1);
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + QCW'(1);
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         head_mem[wptr_ff] <= wr_head;
         cnt_mem[wptr_ff]  <= wr_cnt;
         vis_mem[wptr_ff]  <= wr_vis;
      end
   end

endmodule

`default_nettype wire

// ===== sv/pstv_back.sv =====
// Back end: walks one queued job, emitting lead silence, the visemes and an
// optional closing silence into a result register. Holds the running time.
`default_nettype none
`include "pinyin_syllable_to_viseme_timing_unit_defines.svh"

module pstv_back import pstv_pkg::*; #(
   parameter int MAX_VISEMES = MAX_VISEMES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   output logic                             q_pop,
   input  job_head_type                     job_head,
   input  logic [$clog2(MAX_VISEMES+1)-1:0] job_cnt,
   input  logic [VIS_W-1:0]                 job_vis [MAX_VISEMES],
   output logic                             empty,
   input  logic                             pop,
   output logic [VIS_W-1:0]                 rsp_viseme,
   output logic [TIME_W-1:0]                rsp_begin_time,
   output logic                             rsp_run_end
);

   localparam int VCW = $clog2(MAX_VISEMES + 1);
   localparam int VIW = $clog2(MAX_VISEMES);

   typedef enum logic [2:0] {
      B_LEAD  = 3'b001,
      B_VIS   = 3'b010,
      B_CLOSE = 3'b100
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [VCW-1:0]    idx_ff, idx_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic              valid_ff, valid_in;
   logic [VIS_W-1:0]  vis_ff, vis_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic              end_ff, end_in;

   logic              go;
   logic              last_vis;

   assign go          = (!valid_ff || pop) && !q_empty;
   assign last_vis    = (idx_ff == job_cnt - VCW'(1));
   assign empty       = !valid_ff;
   assign rsp_viseme     = vis_ff;
   assign rsp_begin_time = time_ff;
   assign rsp_run_end    = end_ff;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      elapsed_in = elapsed_ff;
      vis_in     = vis_ff;
      time_in    = time_ff;
      end_in     = end_ff;
      q_pop      = 1'b0;
      valid_in   = pop ? 1'b0 : valid_ff;
      if (go) begin
         valid_in = 1'b1;
         time_in  = elapsed_ff;
         unique case (state_ff)
            B_LEAD: begin
               vis_in     = VIS_SILENCE;
               end_in     = 1'b0;
               elapsed_in = elapsed_ff + {{(TIME_W - STEP_W){1'b0}},
                                          job_head.pause_ms, {FRAC_W{1'b0}}};
               idx_in     = '0;
               state_in   = B_VIS;
            end
            B_VIS: begin
               vis_in     = job_vis[idx_ff[VIW-1:0]];
               end_in     = last_vis && !job_head.final_syl;
               elapsed_in = elapsed_ff + {{(TIME_W - STEP_W){1'b0}}, job_head.step};
               idx_in     = idx_ff + VCW'(1);
               if (last_vis) begin
                  if (job_head.final_syl) begin
                     state_in = B_CLOSE;
                  end else begin
                     q_pop    = 1'b1;
                     state_in = B_LEAD;
                  end
               end
            end
            B_CLOSE: begin
               vis_in     = VIS_SILENCE;
               end_in     = 1'b1;
               elapsed_in = '0;
               q_pop      = 1'b1;
               state_in   = B_LEAD;
            end
            default: begin
               state_in = B_LEAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_LEAD;
         idx_ff     <= '0;
         elapsed_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         elapsed_ff <= elapsed_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vis_ff  <= vis_in;
      time_ff <= time_in;
      end_ff  <= end_in;
   end

   `PSTV_ASSERT_IMP(a_run_end_pops, clock, reset, go && end_in, q_pop, "run end without job release")
   `PSTV_ASSERT_IMP(a_pop_on_run_end, clock, reset, q_pop, go && end_in, "job released early")
   `PSTV_ASSERT_NXT(a_close_clears_time, clock, reset, go && state_ff == B_CLOSE, elapsed_ff == '0, "time not cleared after close")
   `PSTV_ASSERT_IMP(a_index_in_range, clock, reset, state_ff == B_VIS && !q_empty, idx_ff < job_cnt, "viseme index past count")

endmodule

`default_nettype wire

// ===== sv/pinyin_syllable_to_viseme_timing_unit.sv =====
// Pinyin syllable to viseme timing unit, top level.
// Ties the letter scan front end, the job queue and the emit back end.
//
// Usage:
//   Request side is a queue: drive one syllable (six letter codes, pause,
//   duration, final flag) and raise push; it is taken on a clock edge with
//   push high and full low. full stays high while the front end works.
//   Result side is a queue too: while empty is low, rsp_* hold the oldest
//   viseme; pop on a clock with empty low takes it.
//   Each request yields a lead silence, 1..MAX_VISEMES visemes, and on the
//   final syllable a closing silence; rsp_run_end marks its last result.
// Timing:
//   Front end per request: an accept step, one scan step per letter group (at
//   most MAX_LETTERS) plus a closing scan step, 4-bit-per-cycle division and
//   a hand-off step that waits while the job queue is full.
//   First result: job queue, then result register. The back end gives one
//   result per cycle while jobs wait and pop keeps up, overlapping the next scan.
// Stalls: a held-off pop freezes the result register and the back end; the
//   two-entry job queue then fills and full holds off new requests.
// Reset (synchronous): queues empty, running time zero, no clearing pass.
`default_nettype none

module pinyin_syllable_to_viseme_timing_unit import pstv_pkg::*; #(
   parameter int MAX_LETTERS = MAX_LETTERS_DEF,
   parameter int MAX_VISEMES = MAX_VISEMES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [LTR_W-1:0]  req_letter_a,
   input  logic [LTR_W-1:0]  req_letter_b,
   input  logic [LTR_W-1:0]  req_letter_c,
   input  logic [LTR_W-1:0]  req_letter_d,
   input  logic [LTR_W-1:0]  req_letter_e,
   input  logic [LTR_W-1:0]  req_letter_f,
   input  logic [MS_W-1:0]   req_pause_ms,
   input  logic [MS_W-1:0]   req_duration_ms,
   input  logic              req_final_syllable,
   output logic              empty,
   input  logic              pop,
   output logic [VIS_W-1:0]  rsp_viseme,
   output logic [TIME_W-1:0] rsp_begin_time,
   output logic              rsp_run_end
);

   localparam int VCW = $clog2(MAX_VISEMES + 1);

   // front end -> queue
   logic             fq_push;
   logic             fq_full;
   job_head_type     fq_head;
   logic [VCW-1:0]   fq_cnt;
   logic [VIS_W-1:0] fq_vis [MAX_VISEMES];

   // queue -> back end
   logic             qb_pop;
   logic             qb_empty;
   job_head_type     qb_head;
   logic [VCW-1:0]   qb_cnt;
   logic [VIS_W-1:0] qb_vis [MAX_VISEMES];

   pstv_front #(
      .MAX_LETTERS (MAX_LETTERS),
      .MAX_VISEMES (MAX_VISEMES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_letter_a       (req_letter_a),
      .req_letter_b       (req_letter_b),
      .req_letter_c       (req_letter_c),
      .req_letter_d       (req_letter_d),
      .req_letter_e       (req_letter_e),
      .req_letter_f       (req_letter_f),
      .req_pause_ms       (req_pause_ms),
      .req_duration_ms    (req_duration_ms),
      .req_final_syllable (req_final_syllable),
      .q_full             (fq_full),
      .q_push             (fq_push),
      .job_head           (fq_head),
      .job_cnt            (fq_cnt),
      .job_vis            (fq_vis)
   );

   pstv_queue #(
      .MAX_VISEMES (MAX_VISEMES)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (fq_push),
      .wr_full  (fq_full),
      .wr_head  (fq_head),
      .wr_cnt   (fq_cnt),
      .wr_vis   (fq_vis),
      .rd_pop   (qb_pop),
      .rd_empty (qb_empty),
      .rd_head  (qb_head),
      .rd_cnt   (qb_cnt),
      .rd_vis   (qb_vis)
   );

   pstv_back #(
      .MAX_VISEMES (MAX_VISEMES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (qb_empty),
      .q_pop          (qb_pop),
      .job_head       (qb_head),
      .job_cnt        (qb_cnt),
      .job_vis        (qb_vis),
      .empty          (empty),
      .pop            (pop),
      .rsp_viseme     (rsp_viseme),
      .rsp_begin_time (rsp_begin_time),
      .rsp_run_end    (rsp_run_end)
   );

endmodule

`default_nettype wire

// ===== sim/tb_pinyin_syllable_to_viseme_timing_unit.sv =====
// Self-checking testbench for the pinyin syllable to viseme timing unit.
// Needs the RTL package pstv_pkg and the top module pinyin_syllable_to_viseme_timing_unit.
// Directed spellings, result hold-off and random utterances under idling.
`default_nettype none

module tb_pinyin_syllable_to_viseme_timing_unit import pstv_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   // scan sizes match the DUT's default parameters
   localparam int LETTER_LIMIT = MAX_LETTERS_DEF;
   localparam int VIS_LIMIT    = MAX_VISEMES_DEF;
   // scan window: letters plus lookahead, always padded with "none"
   localparam int LETTER_BUF   = LETTER_LIMIT + LOOKAHEAD + 1;
   localparam int NUM_SPELLINGS = 40;
   // pause/duration floor for near full-scale times
   localparam int LONG_MS_FLOOR = 62000;
   localparam int RANDOM_PER_PHASE = 21;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int TAIL_CYCLES = 64;

   typedef logic [LTR_W-1:0] letter_type;
   typedef logic [VIS_W-1:0] viseme_type;

   // one syllable request, letter index 0 is letter_a
   typedef struct packed {
      logic [LETTER_PORTS-1:0][LTR_W-1:0] letters;
      logic [MS_W-1:0]                    pause_ms;
      logic [MS_W-1:0]                    duration_ms;
      logic                               final_syl;
   } syllable_type;

   // one timed viseme on the result side
   typedef struct packed {
      viseme_type        viseme;
      logic [TIME_W-1:0] begin_time;
      logic              run_end;
   } viseme_event_type;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // clock, reset and DUT ports; every input known from time zero
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   letter_type        req_letter_a = '0;
   letter_type        req_letter_b = '0;
   letter_type        req_letter_c = '0;
   letter_type        req_letter_d = '0;
   letter_type        req_letter_e = '0;
   letter_type        req_letter_f = '0;
   logic [MS_W-1:0]   req_pause_ms = '0;
   logic [MS_W-1:0]   req_duration_ms = '0;
   logic              req_final_syllable = 1'b0;
   logic              empty;
   logic              pop = 1'b0;
   viseme_type        rsp_viseme;
   logic [TIME_W-1:0] rsp_begin_time;
   logic              rsp_run_end;

   // predictor state: running time in 1/256 ms, and the scan work area
   logic [TIME_W-1:0] running_time = '0;
   letter_type        scan_ltr [0:LETTER_BUF-1];
   viseme_type        kept_vis [0:VIS_LIMIT-1];
   int unsigned       kept_cnt;

   viseme_event_type  pending_visemes [$];
   int                error_count = 0;

   // idling control; pop_hold_left is a long hold-off counted by the pop process
   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;
   int                pop_hold_left = 0;

   // real pinyin spellings used as the bulk of the random letters
   string spellings [0:NUM_SPELLINGS-1] = '{
      "ba", "pao", "mei", "fang", "feng", "fou", "dan", "tuo", "nv", "nve",
      "lian", "gua", "kuo", "huang", "jiong", "qiu", "xue", "zhuan", "chong", "shi",
      "ri", "zi", "cong", "song", "an", "ou", "er", "yong", "yun", "yin",
      "wu", "wai", "weng", "niang", "shuang", "chuang", "lvn", "xiong", "yo", "e"
   };

   pinyin_syllable_to_viseme_timing_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_letter_a       (req_letter_a),
      .req_letter_b       (req_letter_b),
      .req_letter_c       (req_letter_c),
      .req_letter_d       (req_letter_d),
      .req_letter_e       (req_letter_e),
      .req_letter_f       (req_letter_f),
      .req_pause_ms       (req_pause_ms),
      .req_duration_ms    (req_duration_ms),
      .req_final_syllable (req_final_syllable),
      .empty              (empty),
      .pop                (pop),
      .rsp_viseme         (rsp_viseme),
      .rsp_begin_time     (rsp_begin_time),
      .rsp_run_end        (rsp_run_end)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Viseme predictor
   // ---------------------------------------------------------------------

   // keep a viseme unless the list is already full
   function automatic void put_viseme(input viseme_type v);
      if (kept_cnt < VIS_LIMIT) begin
         kept_vis[kept_cnt] = v;
         kept_cnt++;
      end
   endfunction

   // rounded vowel: lift the last kept consonant shape by one
   function automatic void round_last();
      if (kept_cnt > 0 && kept_vis[kept_cnt-1] < VIS_ROUND_LIMIT)
         kept_vis[kept_cnt-1] = kept_vis[kept_cnt-1] + 1'b1;
   endfunction

   // letter scan with three letters of lookahead; fills kept_vis/kept_cnt
   function automatic void scan_syllable(input syllable_type s);
      int         pos;
      int         k;
      bit         stopped;
      letter_type cur;
      letter_type n1;
      letter_type n2;
      letter_type n3;
      viseme_type last;
      for (k = 0; k < LETTER_BUF; k++)
         scan_ltr[k] = LTR_NONE;
      // scan stops at the first none or out-of-range code; later letters ignored
      stopped = 1'b0;
      for (k = 0; k < LETTER_LIMIT; k++) begin
         cur = (k < LETTER_PORTS) ? s.letters[k] : LTR_NONE;
         if (cur == LTR_NONE || cur > LTR_LAST)
            stopped = 1'b1;
         if (!stopped)
            scan_ltr[k] = cur;
      end
      kept_cnt = 0;
      pos = 0;
      while (pos < LETTER_LIMIT && scan_ltr[pos] != LTR_NONE) begin
         cur = scan_ltr[pos];
         n1  = scan_ltr[pos+1];
         n2  = scan_ltr[pos+2];
         n3  = scan_ltr[pos+3];
         case (cur)
            LTR_B, LTR_P, LTR_M: put_viseme(VIS_BPM);
            LTR_F: begin
               put_viseme(VIS_F);
               if (n1 == LTR_U) begin
                  put_viseme(VIS_F);
                  pos++;
               end
            end
            LTR_D, LTR_T, LTR_N: put_viseme(VIS_DTN);
            LTR_L: put_viseme(VIS_L);
            LTR_G, LTR_K, LTR_H: put_viseme(VIS_GKH);
            LTR_J, LTR_Q, LTR_X: put_viseme(VIS_JQX);
            LTR_Z, LTR_C, LTR_S: begin
               if (n1 == LTR_H) begin
                  put_viseme(VIS_RETRO);
                  pos++;
               end else begin
                  put_viseme(VIS_ZCS);
               end
            end
            LTR_R: put_viseme(VIS_RETRO);
            LTR_A: begin
               if (n1 == LTR_O) begin
                  put_viseme(VIS_AO);
                  pos++;
               end else if (n1 == LTR_I) begin
                  put_viseme(VIS_AI);
                  pos++;
               end else if (n1 == LTR_N && n2 == LTR_G) begin
                  put_viseme(VIS_A);
                  pos += 2;
               end else if (n1 == LTR_N) begin
                  put_viseme(VIS_AI);
                  pos++;
               end else begin
                  put_viseme(VIS_A);
               end
            end
            LTR_O: begin
               if (n1 == LTR_U) begin
                  put_viseme(VIS_OU);
                  pos++;
               end else if (n1 == LTR_N && n2 == LTR_G) begin
                  round_last();
                  put_viseme(VIS_U);
                  pos += 2;
               end else begin
                  put_viseme(VIS_O);
               end
            end
            LTR_E: begin
               if (n1 == LTR_I || n1 == LTR_N) begin
                  put_viseme(VIS_EI);
                  pos += (n1 == LTR_N && n2 == LTR_G) ? 2 : 1;
               end else if (n1 == LTR_R) begin
                  put_viseme(VIS_ER);
                  pos++;
               end else begin
                  put_viseme(VIS_E);
               end
            end
            LTR_I: begin
               last = (kept_cnt > 0) ? kept_vis[kept_cnt-1] : VIS_SILENCE;
               // i after j/q/x, zh/ch/sh/r or z/c/s repeats the consonant shape
               if (kept_cnt > 0 && (last == VIS_JQX || last == VIS_RETRO || last == VIS_ZCS)) begin
                  put_viseme(last);
               end else if (n1 == LTR_O && n2 == LTR_N && n3 == LTR_G) begin
                  round_last();
                  put_viseme(VIS_YU);
                  put_viseme(VIS_EI);
                  pos += 3;
               end else begin
                  put_viseme(VIS_I);
                  if (n1 == LTR_N) begin
                     put_viseme(VIS_EI);
                     pos += (n2 == LTR_G) ? 2 : 1;
                  end
               end
            end
            LTR_U: begin
               round_last();
               if (n1 == LTR_E) begin
                  put_viseme(VIS_YU);
                  put_viseme(VIS_E);
                  pos++;
               end else if (n1 == LTR_N) begin
                  put_viseme(VIS_U);
                  put_viseme(VIS_EI);
                  pos++;
               end else if (pos > 0 && scan_ltr[pos-1] == LTR_Y) begin
                  put_viseme(VIS_YU);
               end else begin
                  put_viseme(VIS_U);
               end
            end
            LTR_V: begin
               round_last();
               put_viseme(VIS_YU);
               if (n1 == LTR_E) begin
                  put_viseme(VIS_E);
                  pos++;
               end else if (n1 == LTR_N) begin
                  put_viseme(VIS_EI);
                  pos++;
               end
            end
            // y and w give nothing without a fitting follower
            LTR_Y: begin
               if (n1 == LTR_A || n1 == LTR_E) begin
                  put_viseme(VIS_I);
               end else if (n1 == LTR_O && n2 == LTR_U) begin
                  put_viseme(VIS_I);
                  put_viseme(VIS_OU);
                  pos += 2;
               end else if (n1 == LTR_O && n2 == LTR_N && n3 == LTR_G) begin
                  put_viseme(VIS_YU);
                  pos += 3;
               end
            end
            LTR_W_: begin
               if (n1 == LTR_A || n1 == LTR_E)
                  put_viseme(VIS_U);
            end
            default: ;
         endcase
         pos++;
      end
      // empty syllable still holds one closed-mouth viseme
      if (kept_cnt == 0)
         put_viseme(VIS_SILENCE);
   endfunction

   function automatic void expect_viseme(input viseme_type v, input logic [TIME_W-1:0] t,
                                         input logic last);
      viseme_event_type ev;
      ev.viseme     = v;
      ev.begin_time = t;
      ev.run_end    = last;
      pending_visemes = {pending_visemes, ev};
   endfunction

   // lead silence, pause, spaced visemes, optional closing silence
   function automatic void predict_visemes(input syllable_type s);
      logic [TIME_W-1:0] step;
      int unsigned       total;
      int unsigned       k;
      scan_syllable(s);
      total = 1 + kept_cnt + (s.final_syl ? 1 : 0);
      expect_viseme(VIS_SILENCE, running_time, total == 1);
      running_time = running_time + {8'd0, s.pause_ms, 8'd0};
      // truncating divide of the duration over the kept visemes
      step = {8'd0, s.duration_ms, 8'd0} / kept_cnt;
      for (k = 0; k < kept_cnt; k++) begin
         expect_viseme(kept_vis[k], running_time, k + 2 == total);
         running_time = running_time + step;
      end
      if (s.final_syl) begin
         expect_viseme(VIS_SILENCE, running_time, 1'b1);
         running_time = '0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result side: compare on accept, then choose next pop
   // ---------------------------------------------------------------------

   function automatic void check_result();
      viseme_event_type want;
      if (pending_visemes.size() == 0) begin
         $display("%0t: unexpected result: viseme %0d time %0d run_end %0d",
                  $time, rsp_viseme, rsp_begin_time, rsp_run_end);
         error_count++;
      end else begin
         want = pending_visemes.pop_front();
         if (rsp_viseme !== want.viseme) begin
            $display("%0t: viseme mismatch: expected %0d, actual %0d",
                     $time, want.viseme, rsp_viseme);
            error_count++;
         end
         if (rsp_begin_time !== want.begin_time) begin
            $display("%0t: begin_time mismatch: expected %0d, actual %0d",
                     $time, want.begin_time, rsp_begin_time);
            error_count++;
         end
         if (rsp_run_end !== want.run_end) begin
            $display("%0t: run_end mismatch: expected %0d, actual %0d",
                     $time, want.run_end, rsp_run_end);
            error_count++;
         end
      end
   endfunction

   // pop and empty are sampled as they stood just before this edge
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty)
            check_result();
         if (pop_hold_left > 0) begin
            pop_hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // push stays high across back-to-back requests; lowered only for idle gaps and drains
   task automatic send_syllable(input syllable_type s);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push               <= 1'b1;
      req_letter_a       <= s.letters[0];
      req_letter_b       <= s.letters[1];
      req_letter_c       <= s.letters[2];
      req_letter_d       <= s.letters[3];
      req_letter_e       <= s.letters[4];
      req_letter_f       <= s.letters[5];
      req_pause_ms       <= s.pause_ms;
      req_duration_ms    <= s.duration_ms;
      req_final_syllable <= s.final_syl;
      do @(posedge clock); while (full);
      predict_visemes(s);
   endtask

   // sender goes quiet until every predicted viseme has been taken
   task automatic wait_drained();
      push <= 1'b0;
      while (pending_visemes.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct = 0;  receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 48; receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;  receiver_stall_pct = 48;
         end
         IDLE_BOTH: begin
            sender_idle_pct = 23; receiver_stall_pct = 23;
         end
      endcase
   endtask

   function automatic syllable_type spell_syllable(input string txt, input int pause,
                                                   input int dur, input bit fin);
      syllable_type s;
      int           k;
      s = '0;
      for (k = 0; k < LETTER_PORTS && k < txt.len(); k++)
         s.letters[k] = LTR_A + letter_type'(txt[k] - "a");
      s.pause_ms    = MS_W'(pause);
      s.duration_ms = MS_W'(dur);
      s.final_syl   = fin;
      return s;
   endfunction

   function automatic logic [MS_W-1:0] random_ms(input bit near_max);
      int pick;
      if (near_max)
         return MS_W'($urandom_range(16'hFFFF, LONG_MS_FLOOR));
      pick = $urandom_range(9);
      if (pick < 2)
         return MS_W'($urandom_range(15));
      if (pick == 2)
         return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      return MS_W'($urandom_range(16'hFFFF));
   endfunction

   // mostly real spellings, some random letter runs, some raw 5-bit noise
   function automatic syllable_type random_syllable(input bit near_max, input bit fin);
      syllable_type s;
      int           pick;
      int           n;
      int           k;
      pick = $urandom_range(9);
      if (pick < 6) begin
         s = spell_syllable(spellings[$urandom_range(NUM_SPELLINGS-1)], 0, 0, 1'b0);
      end else begin
         s = '0;
         n = $urandom_range(LETTER_PORTS);
         for (k = 0; k < LETTER_PORTS; k++) begin
            if (pick < 8)
               s.letters[k] = (k < n) ? letter_type'($urandom_range(LTR_LAST, LTR_A))
                                      : LTR_NONE;
            else
               s.letters[k] = letter_type'($urandom_range(31));
         end
      end
      s.pause_ms    = random_ms(near_max);
      s.duration_ms = random_ms(near_max);
      s.final_syl   = fin;
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // initials and plain finals; zero and full-scale times among them
   task automatic test_consonant_groups();
      send_syllable(spell_syllable("bang", 0, 0, 1'b0));
      send_syllable(spell_syllable("pan", 12, 200, 1'b0));
      send_syllable(spell_syllable("fu", 16'hFFFF, 16'hFFFF, 1'b0));
      send_syllable(spell_syllable("fo", 30, 150, 1'b0));
      send_syllable(spell_syllable("miao", 5, 333, 1'b1));
   endtask

   task automatic test_vowel_groups();
      send_syllable(spell_syllable("gou", 0, 250, 1'b0));
      send_syllable(spell_syllable("ker", 40, 180, 1'b0));
      send_syllable(spell_syllable("dei", 8, 99, 1'b0));
      send_syllable(spell_syllable("ting", 16, 301, 1'b0));
      send_syllable(spell_syllable("he", 0, 1, 1'b1));
   endtask

   // i after a retroflex, sibilant or palatal repeats the previous shape
   task automatic test_repeated_i();
      send_syllable(spell_syllable("zhi", 20, 240, 1'b0));
      send_syllable(spell_syllable("ci", 0, 120, 1'b0));
      send_syllable(spell_syllable("si", 3, 77, 1'b0));
      send_syllable(spell_syllable("qi", 9, 160, 1'b1));
   endtask

   // u, v, ong and iong lift the consonant before them
   task automatic test_rounding();
      send_syllable(spell_syllable("lve", 10, 300, 1'b0));
      send_syllable(spell_syllable("kun", 0, 211, 1'b0));
      send_syllable(spell_syllable("rong", 14, 190, 1'b0));
      send_syllable(spell_syllable("liong", 2, 400, 1'b0));
      send_syllable(spell_syllable("xiong", 6, 270, 1'b0));
      send_syllable(spell_syllable("ju", 1, 130, 1'b1));
   endtask

   // y/w glides, with and without a follower that gives them a shape
   task automatic test_glides();
      send_syllable(spell_syllable("yong", 25, 222, 1'b0));
      send_syllable(spell_syllable("you", 0, 180, 1'b0));
      send_syllable(spell_syllable("yue", 7, 205, 1'b0));
      send_syllable(spell_syllable("wa", 11, 90, 1'b0));
      send_syllable(spell_syllable("wo", 0, 140, 1'b1));
   endtask

   // none, out-of-range codes and an empty syllable end the scan
   task automatic test_letter_stop();
      syllable_type s;
      send_syllable(spell_syllable("", 4, 100, 1'b0));
      s = spell_syllable("aab", 3, 50, 1'b0);
      s.letters[1] = LTR_NONE;
      send_syllable(s);
      s = spell_syllable("aab", 0, 60, 1'b0);
      s.letters[1] = letter_type'(LTR_LAST + 1'b1);
      send_syllable(s);
      s = spell_syllable("abbang", 9, 70, 1'b1);
      s.letters[2] = 5'h1F;
      send_syllable(s);
   endtask

   // more shapes than the limit: extras dropped, rounding hits the last kept
   task automatic test_viseme_limit();
      send_syllable(spell_syllable("dddddu", 0, 16'hFFFF, 1'b0));
      send_syllable(spell_syllable("fufufu", 16'hFFFF, 7, 1'b1));
      wait_drained();
   endtask

   // long pop hold-off while requests keep coming: the unit must fill and
   // push back with full; then the sender waits for a full drain
   task automatic test_result_holdoff();
      int k;
      set_idling(IDLE_NONE);
      pop_hold_left = HOLDOFF_CYCLES;
      for (k = 0; k < 10; k++)
         send_syllable(random_syllable(1'b0, k == 9));
      wait_drained();
      for (k = 0; k < 4; k++)
         send_syllable(random_syllable(1'b1, k == 3));
      wait_drained();
   endtask

   // utterances of one to six syllables; some are cut off without a final
   task automatic test_random_utterances();
      idle_mode_type modes [0:3] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
      int            m;
      int            sent;
      int            len;
      int            j;
      bit            fin;
      for (m = 0; m < 4; m++) begin
         set_idling(modes[m]);
         sent = 0;
         while (sent < RANDOM_PER_PHASE) begin
            len = $urandom_range(6, 1);
            for (j = 0; j < len && sent < RANDOM_PER_PHASE; j++) begin
               fin = (j == len - 1) && ($urandom_range(5) != 0);
               send_syllable(random_syllable(1'b0, fin));
               sent++;
            end
         end
         wait_drained();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);
      test_consonant_groups();
      test_vowel_groups();
      test_repeated_i();
      test_rounding();
      test_glides();
      test_letter_stop();
      test_viseme_limit();
      test_result_holdoff();
      test_random_utterances();
      // let any stray result show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_pinyin_syllable_to_viseme_timing_unit: done, clean");
      else
         $display("tb_pinyin_syllable_to_viseme_timing_unit: done, errors");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("tb_pinyin_syllable_to_viseme_timing_unit: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
